### src/ccs_pkg.sv
`timescale 1ns / 1ps

package ccs_pkg;

  localparam int STORE_DEPTH = 16;
  localparam int VALUE_WIDTH = 16;

  // address into the store, and a count that can hold the depth itself
  localparam int IDX_W = $clog2(STORE_DEPTH);
  localparam int CNT_W = $clog2(STORE_DEPTH + 1);

  typedef logic signed [VALUE_WIDTH-1:0] value_t;
  typedef logic [IDX_W-1:0]              idx_t;
  typedef logic [CNT_W-1:0]              cnt_t;

  typedef enum logic [9:0] {
    S_LOAD     = 10'b00_0000_0001,
    S_DN_HEAD  = 10'b00_0000_0010,
    S_DN_PRIME = 10'b00_0000_0100,
    S_DN_STEP  = 10'b00_0000_1000,
    S_DN_TAIL  = 10'b00_0001_0000,
    S_UP_HEAD  = 10'b00_0010_0000,
    S_UP_PRIME = 10'b00_0100_0000,
    S_UP_STEP  = 10'b00_1000_0000,
    S_UP_TAIL  = 10'b01_0000_0000,
    S_OUT      = 10'b10_0000_0000
  } state_t;

endpackage

### src/ccs_ram.sv
`timescale 1ns / 1ps

// simple dual-port RAM, one write and one registered read per cycle
module ccs_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

### src/cocktail_shaker_sorter.sv
`timescale 1ns / 1ps

// Cocktail shaker sorter.
// Input: a transfer happens at a clock edge with start high and busy low.
//   Each transfer writes in_sample_value into the next free store entry;
//   when the store (16 entries) is full the value is dropped and the set is
//   marked as overflowed. A transfer with in_final_item high closes the set
//   (its own value is stored first if there is room) and starts the sort;
//   a set of a single value goes straight to output.
// Sort: bidirectional bubble passes over the store RAM. Each pass carries
//   one value in a register, reads one neighbor per cycle and writes the
//   larger/smaller one back, with head, prime and tail steps around the
//   compare-swaps of each pass; the speed of the sort is bounded by the
//   single RAM read port.
// Output: the n sorted values follow on back-to-back cycles, each shown for
//   exactly one cycle with out_valid high; out_end_of_set marks the last one
//   and out_overflow_flag is high on every value of an overflowed set.
//   The receiver cannot stall. busy drops while the last value is on the
//   ports, so a new set may start in that cycle. Loading is one item per
//   cycle.
// Reset (rst_n low, synchronous) empties the set and returns to loading;
//   the store contents are not cleared and are never read before written.
module cocktail_shaker_sorter (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                start,
  output logic                                busy,
  input  logic signed [ccs_pkg::VALUE_WIDTH-1:0] in_sample_value,
  input  logic                                in_final_item,
  output logic                                out_valid,
  output logic signed [ccs_pkg::VALUE_WIDTH-1:0] out_sorted_value,
  output logic                                out_end_of_set,
  output logic                                out_overflow_flag
);

  ccs_pkg::state_t state_r, state_nxt;

  // fill count, pass bounds and scan position
  ccs_pkg::cnt_t fill_r, fill_nxt;
  ccs_pkg::cnt_t lo_r, lo_nxt;
  ccs_pkg::cnt_t hi_r, hi_nxt;
  ccs_pkg::cnt_t scan_r, scan_nxt;
  ccs_pkg::cnt_t scan_inc, scan_dec, scan_dec2, lo_inc, lo_dec, hi_dec;

  logic drop_r, drop_nxt;

  // the value that travels along the current pass
  ccs_pkg::value_t carry_r, carry_nxt;

  logic out_vld_r, out_vld_nxt;
  logic out_end_r, out_end_nxt;
  logic out_ovf_r, out_ovf_nxt;

  // store RAM ports
  logic                                 ram_we;
  ccs_pkg::idx_t                        ram_waddr;
  ccs_pkg::idx_t                        ram_raddr;
  logic [ccs_pkg::VALUE_WIDTH-1:0]      ram_wdata;
  logic [ccs_pkg::VALUE_WIDTH-1:0]      ram_rdata;
  ccs_pkg::value_t                      rd_val;
  logic                                 left_gt;

  ccs_ram #(
    .WIDTH (ccs_pkg::VALUE_WIDTH),
    .DEPTH (ccs_pkg::STORE_DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign rd_val    = $signed(ram_rdata);
  assign scan_inc  = scan_r + ccs_pkg::CNT_W'(1);
  assign scan_dec  = scan_r - ccs_pkg::CNT_W'(1);
  assign scan_dec2 = scan_r - ccs_pkg::CNT_W'(2);
  assign lo_inc    = lo_r + ccs_pkg::CNT_W'(1);
  assign lo_dec    = lo_r - ccs_pkg::CNT_W'(1);
  assign hi_dec    = hi_r - ccs_pkg::CNT_W'(1);

  always_comb begin
    state_nxt   = state_r;
    fill_nxt    = fill_r;
    lo_nxt      = lo_r;
    hi_nxt      = hi_r;
    scan_nxt    = scan_r;
    drop_nxt    = drop_r;
    carry_nxt   = carry_r;
    out_vld_nxt = 1'b0;
    out_end_nxt = 1'b0;
    out_ovf_nxt = out_ovf_r;
    ram_we      = 1'b0;
    ram_waddr   = scan_r[ccs_pkg::IDX_W-1:0];
    ram_wdata   = carry_r;
    ram_raddr   = scan_r[ccs_pkg::IDX_W-1:0];
    left_gt     = 1'b0;

    unique case (state_r)
      ccs_pkg::S_LOAD: begin
        if (start) begin
          if (fill_r < ccs_pkg::CNT_W'(ccs_pkg::STORE_DEPTH)) begin
            ram_we    = 1'b1;
            ram_waddr = fill_r[ccs_pkg::IDX_W-1:0];
            ram_wdata = in_sample_value;
            fill_nxt  = fill_r + ccs_pkg::CNT_W'(1);
          end else begin
            drop_nxt = 1'b1;
          end
          if (in_final_item) begin
            lo_nxt   = ccs_pkg::CNT_W'(1);
            hi_nxt   = fill_nxt - ccs_pkg::CNT_W'(1);
            scan_nxt = '0;
            if (fill_nxt > ccs_pkg::CNT_W'(1)) begin
              state_nxt = ccs_pkg::S_DN_HEAD;
            end else begin
              state_nxt = ccs_pkg::S_OUT;
            end
          end
        end
      end

      // downward pass: carry moves toward the low end holding the minimum
      ccs_pkg::S_DN_HEAD: begin
        ram_raddr = hi_r[ccs_pkg::IDX_W-1:0];
        scan_nxt  = hi_r;
        state_nxt = ccs_pkg::S_DN_PRIME;
      end

      ccs_pkg::S_DN_PRIME: begin
        carry_nxt = rd_val;
        ram_raddr = scan_dec[ccs_pkg::IDX_W-1:0];
        state_nxt = ccs_pkg::S_DN_STEP;
      end

      ccs_pkg::S_DN_STEP: begin
        // left is store[scan-1], right is the carry
        left_gt   = rd_val > carry_r;
        ram_we    = 1'b1;
        ram_waddr = scan_r[ccs_pkg::IDX_W-1:0];
        ram_wdata = left_gt ? rd_val : carry_r;
        carry_nxt = left_gt ? carry_r : rd_val;
        if (scan_r == lo_r) begin
          state_nxt = ccs_pkg::S_DN_TAIL;
        end else begin
          scan_nxt  = scan_dec;
          ram_raddr = scan_dec2[ccs_pkg::IDX_W-1:0];
        end
      end

      ccs_pkg::S_DN_TAIL: begin
        ram_we    = 1'b1;
        ram_waddr = lo_dec[ccs_pkg::IDX_W-1:0];
        ram_wdata = carry_r;
        lo_nxt    = lo_inc;
        if (lo_inc <= hi_r) begin
          state_nxt = ccs_pkg::S_UP_HEAD;
        end else begin
          scan_nxt  = '0;
          state_nxt = ccs_pkg::S_OUT;
        end
      end

      // upward pass: carry moves toward the high end holding the maximum
      ccs_pkg::S_UP_HEAD: begin
        ram_raddr = lo_dec[ccs_pkg::IDX_W-1:0];
        scan_nxt  = lo_r;
        state_nxt = ccs_pkg::S_UP_PRIME;
      end

      ccs_pkg::S_UP_PRIME: begin
        carry_nxt = rd_val;
        ram_raddr = scan_r[ccs_pkg::IDX_W-1:0];
        state_nxt = ccs_pkg::S_UP_STEP;
      end

      ccs_pkg::S_UP_STEP: begin
        // left is the carry, right is store[scan]
        left_gt   = carry_r > rd_val;
        ram_we    = 1'b1;
        ram_waddr = scan_dec[ccs_pkg::IDX_W-1:0];
        ram_wdata = left_gt ? rd_val : carry_r;
        carry_nxt = left_gt ? carry_r : rd_val;
        if (scan_r == hi_r) begin
          state_nxt = ccs_pkg::S_UP_TAIL;
        end else begin
          scan_nxt  = scan_inc;
          ram_raddr = scan_inc[ccs_pkg::IDX_W-1:0];
        end
      end

      ccs_pkg::S_UP_TAIL: begin
        ram_we    = 1'b1;
        ram_waddr = hi_r[ccs_pkg::IDX_W-1:0];
        ram_wdata = carry_r;
        hi_nxt    = hi_dec;
        if (lo_r <= hi_dec) begin
          state_nxt = ccs_pkg::S_DN_HEAD;
        end else begin
          scan_nxt  = '0;
          state_nxt = ccs_pkg::S_OUT;
        end
      end

      // stream the store out; read data is registered and shows up in the following cycle
      ccs_pkg::S_OUT: begin
        ram_raddr   = scan_r[ccs_pkg::IDX_W-1:0];
        out_vld_nxt = 1'b1;
        out_end_nxt = (scan_inc == fill_r);
        out_ovf_nxt = drop_r;
        if (scan_inc == fill_r) begin
          fill_nxt  = '0;
          drop_nxt  = 1'b0;
          scan_nxt  = '0;
          state_nxt = ccs_pkg::S_LOAD;
        end else begin
          scan_nxt = scan_inc;
        end
      end

      default: begin
        state_nxt = ccs_pkg::S_LOAD;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ccs_pkg::S_LOAD;
      fill_r    <= '0;
      lo_r      <= '0;
      hi_r      <= '0;
      scan_r    <= '0;
      drop_r    <= 1'b0;
      out_vld_r <= 1'b0;
      out_end_r <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      fill_r    <= fill_nxt;
      lo_r      <= lo_nxt;
      hi_r      <= hi_nxt;
      scan_r    <= scan_nxt;
      drop_r    <= drop_nxt;
      out_vld_r <= out_vld_nxt;
      out_end_r <= out_end_nxt;
    end
  end

  always_ff @(posedge clk) begin
    carry_r   <= carry_nxt;
    out_ovf_r <= out_ovf_nxt;
  end

  assign busy              = (state_r != ccs_pkg::S_LOAD);
  assign out_valid         = out_vld_r;
  assign out_sorted_value  = rd_val;
  assign out_end_of_set    = out_end_r;
  assign out_overflow_flag = out_ovf_r;

endmodule

### src/ccs_checker.sv
`timescale 1ns / 1ps

module ccs_checker (
  input logic                                   clk,
  input logic                                   rst_n,
  input logic                                   start,
  input logic                                   busy,
  input logic                                   in_final_item,
  input logic                                   out_valid,
  input logic signed [ccs_pkg::VALUE_WIDTH-1:0] out_sorted_value,
  input logic                                   out_end_of_set,
  input logic                                   out_overflow_flag
);

  // closing a set always makes the block busy
  a_final_busy: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy && in_final_item |=> busy)
    else $error("final transfer did not start the sort");

  // results of one set come out without gaps
  a_burst: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_end_of_set |=> out_valid)
    else $error("gap inside a result burst");

  a_end_gap: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_end_of_set |=> !out_valid)
    else $error("result right after end of set");

  // values come out in ascending order
  a_sorted: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_end_of_set |=> out_sorted_value >= $past(out_sorted_value))
    else $error("results out of order");

  a_ovf_const: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_end_of_set |=> out_overflow_flag == $past(out_overflow_flag))
    else $error("overflow flag changed inside a set");

endmodule

bind cocktail_shaker_sorter ccs_checker u_ccs_checker (
  .clk               (clk),
  .rst_n             (rst_n),
  .start             (start),
  .busy              (busy),
  .in_final_item     (in_final_item),
  .out_valid         (out_valid),
  .out_sorted_value  (out_sorted_value),
  .out_end_of_set    (out_end_of_set),
  .out_overflow_flag (out_overflow_flag)
);
